[rtl/itsdf_pkg.sv]
// Shared types and constants for the IPv6 TCP service drop filter.
// Holds the input and result beat structs, table interface structs and header offsets.
// No dependencies.
package itsdf_pkg;

    localparam logic REQ_PKT   = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [6:0] LEN_ETH  = 7'd14;
    localparam logic [6:0] LEN_IPV6 = 7'd54;
    localparam logic [6:0] LEN_TCP  = 7'd74;

    localparam logic [6:0] POS_ETYPE_HI = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO = 7'd13;
    localparam logic [6:0] POS_NEXT_HDR = 7'd20;
    localparam logic [6:0] POS_DADDR_HI = 7'd38;
    localparam logic [6:0] POS_DADDR_LO = 7'd46;
    localparam logic [6:0] POS_DADDR_END = 7'd53;
    localparam logic [6:0] POS_DPORT_HI = 7'd56;
    localparam logic [6:0] POS_DPORT_LO = 7'd57;

    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;

    typedef enum logic [2:0] {
        CAUSE_TRUNC_ETH  = 3'd0,
        CAUSE_NOT_IPV6   = 3'd1,
        CAUSE_TRUNC_IPV6 = 3'd2,
        CAUSE_NOT_TCP    = 3'd3,
        CAUSE_TRUNC_TCP  = 3'd4,
        CAUSE_LOOKUP     = 3'd5
    } cause_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  pkt_byte;
        logic        pkt_last;
        logic [5:0]  entry_index;
        logic        entry_valid;
        logic [63:0] entry_addr_hi;
        logic [63:0] entry_addr_lo;
        logic [15:0] entry_port;
    } in_beat_t;

    typedef struct packed {
        logic       drop;
        logic [2:0] cause;
        logic       matched;
        logic [5:0] match_index;
    } out_beat_t;

    typedef struct packed {
        logic        en;
        logic [5:0]  index;
        logic        valid;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
    } tbl_wr_t;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port;
    } svc_key_t;

endpackage

[rtl/itsdf_svc_table.sv]
// Service table: per-slot address and port registers with parallel exact-match compare.
// Depends on itsdf_pkg.
module itsdf_svc_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  itsdf_pkg::tbl_wr_t       wr,
    input  itsdf_pkg::svc_key_t      key,
    output logic [TABLE_ENTRIES-1:0] hit
);
    import itsdf_pkg::*;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    svc_key_t                 entry_reg [TABLE_ENTRIES];

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_slot
        logic sel;

        assign sel = wr.en && (9'(wr.index) == 9'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (sel) begin
                valid_reg[i] <= wr.valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (sel && wr.valid) begin
                entry_reg[i] <= '{addr_hi: wr.addr_hi, addr_lo: wr.addr_lo, port: wr.port};
            end
        end

        assign hit[i] = valid_reg[i] && (entry_reg[i] == key);
    end

endmodule

[rtl/ipv6_tcp_service_drop_filter.sv]
// IPv6 TCP service drop filter top level: header capture, verdict pipeline, result register.
// Depends on itsdf_pkg and itsdf_svc_table.
// Verdict path: the last byte registers cause and hits, then the result register drives m_.
// Throughput: one beat per cycle, bytes or table writes, no frame gaps, unless m_ stalls.
// Reset clears frame capture state, every table valid bit and both stages' valid bits.
module ipv6_tcp_service_drop_filter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  itsdf_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output itsdf_pkg::out_beat_t  m_data
);
    import itsdf_pkg::*;

    logic [6:0]  byte_count_reg, byte_count_next, count_inc;
    logic [15:0] ethertype_reg, ethertype_next, eth_cap;
    logic [7:0]  next_header_reg, next_header_next, nh_cap;
    logic [63:0] dest_hi_reg, dest_hi_next, dhi_cap;
    logic [63:0] dest_lo_reg, dest_lo_next, dlo_cap;
    logic [15:0] dest_port_reg, dest_port_next, dport_cap;

    logic s_fire, pkt_fire, last_fire, adv2;
    cause_t cause_next, cause2_reg;
    logic vld2_reg, m_valid_reg;
    logic [TABLE_ENTRIES-1:0] hits, hit_vec_reg;
    out_beat_t m_data_reg, out_next;
    logic [5:0] midx;
    tbl_wr_t tbl_wr;
    svc_key_t key;

    assign adv2      = !m_valid_reg || m_ready;
    assign s_ready   = !vld2_reg || adv2;
    assign s_fire    = s_valid && s_ready;
    assign pkt_fire  = s_fire && (s_data.req_type == REQ_PKT);
    assign last_fire = pkt_fire && s_data.pkt_last;

    assign tbl_wr = '{en: s_fire && (s_data.req_type == REQ_WRITE),
                      index: s_data.entry_index, valid: s_data.entry_valid,
                      addr_hi: s_data.entry_addr_hi, addr_lo: s_data.entry_addr_lo,
                      port: s_data.entry_port};
    assign key = '{addr_hi: dest_hi_reg, addr_lo: dest_lo_reg, port: dest_port_reg};

    itsdf_svc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .key     (key),
        .hit     (hits)
    );

    always_comb begin
        eth_cap   = ethertype_reg;
        nh_cap    = next_header_reg;
        dhi_cap   = dest_hi_reg;
        dlo_cap   = dest_lo_reg;
        dport_cap = dest_port_reg;
        if (byte_count_reg == POS_ETYPE_HI || byte_count_reg == POS_ETYPE_LO) begin
            eth_cap = {ethertype_reg[7:0], s_data.pkt_byte};
        end else if (byte_count_reg == POS_NEXT_HDR) begin
            nh_cap = s_data.pkt_byte;
        end else if (byte_count_reg >= POS_DADDR_HI && byte_count_reg < POS_DADDR_LO) begin
            dhi_cap = {dest_hi_reg[55:0], s_data.pkt_byte};
        end else if (byte_count_reg >= POS_DADDR_LO && byte_count_reg <= POS_DADDR_END) begin
            dlo_cap = {dest_lo_reg[55:0], s_data.pkt_byte};
        end else if (byte_count_reg == POS_DPORT_HI || byte_count_reg == POS_DPORT_LO) begin
            dport_cap = {dest_port_reg[7:0], s_data.pkt_byte};
        end
        count_inc = (byte_count_reg < LEN_TCP) ? byte_count_reg + 7'd1 : byte_count_reg;
    end

    always_comb begin
        if (count_inc < LEN_ETH) begin
            cause_next = CAUSE_TRUNC_ETH;
        end else if (eth_cap != ETYPE_IPV6) begin
            cause_next = CAUSE_NOT_IPV6;
        end else if (count_inc < LEN_IPV6) begin
            cause_next = CAUSE_TRUNC_IPV6;
        end else if (nh_cap != PROTO_TCP) begin
            cause_next = CAUSE_NOT_TCP;
        end else if (count_inc < LEN_TCP) begin
            cause_next = CAUSE_TRUNC_TCP;
        end else begin
            cause_next = CAUSE_LOOKUP;
        end
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        ethertype_next   = ethertype_reg;
        next_header_next = next_header_reg;
        dest_hi_next     = dest_hi_reg;
        dest_lo_next     = dest_lo_reg;
        dest_port_next   = dest_port_reg;
        if (last_fire) begin
            byte_count_next  = '0;
            ethertype_next   = '0;
            next_header_next = '0;
            dest_hi_next     = '0;
            dest_lo_next     = '0;
            dest_port_next   = '0;
        end else if (pkt_fire) begin
            byte_count_next  = count_inc;
            ethertype_next   = eth_cap;
            next_header_next = nh_cap;
            dest_hi_next     = dhi_cap;
            dest_lo_next     = dlo_cap;
            dest_port_next   = dport_cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            ethertype_reg   <= '0;
            next_header_reg <= '0;
            dest_hi_reg     <= '0;
            dest_lo_reg     <= '0;
            dest_port_reg   <= '0;
        end else begin
            byte_count_reg  <= byte_count_next;
            ethertype_reg   <= ethertype_next;
            next_header_reg <= next_header_next;
            dest_hi_reg     <= dest_hi_next;
            dest_lo_reg     <= dest_lo_next;
            dest_port_reg   <= dest_port_next;
        end
    end

    // The address and port are complete long before the last byte of a full TCP header,
    // so the compare runs against the held capture registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (s_ready) begin
            vld2_reg <= last_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_fire) begin
            cause2_reg  <= cause_next;
            hit_vec_reg <= (cause_next == CAUSE_LOOKUP) ? hits : '0;
        end
    end

    always_comb begin
        midx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec_reg[i]) begin
                midx = 6'(i);
            end
        end
        out_next.cause       = cause2_reg;
        out_next.matched     = |hit_vec_reg;
        out_next.match_index = midx;
        if (cause2_reg == CAUSE_LOOKUP) begin
            out_next.drop = |hit_vec_reg;
        end else begin
            out_next.drop = (cause2_reg == CAUSE_TRUNC_ETH) ||
                            (cause2_reg == CAUSE_TRUNC_IPV6) ||
                            (cause2_reg == CAUSE_TRUNC_TCP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv2) begin
            m_valid_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && vld2_reg) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/itsdf_checker.sv]
// Port-level checker for the IPv6 TCP service drop filter, bound to the top level.
// Depends on itsdf_pkg and ipv6_tcp_service_drop_filter.
module itsdf_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input itsdf_pkg::out_beat_t  m_data
);
    import itsdf_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_cause_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cause <= CAUSE_LOOKUP)
        else $error("Result cause out of range.");

    a_match_only_on_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.cause != CAUSE_LOOKUP || !m_data.matched)
        |-> !m_data.matched || m_data.cause == CAUSE_LOOKUP)
        else $error("Match reported without a lookup.");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.matched |-> m_data.match_index == 6'd0)
        else $error("Match index set without a match.");

    a_drop_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.drop == ((m_data.cause == CAUSE_LOOKUP) ? m_data.matched :
            (m_data.cause == CAUSE_TRUNC_ETH || m_data.cause == CAUSE_TRUNC_IPV6 ||
             m_data.cause == CAUSE_TRUNC_TCP)))
        else $error("Drop verdict disagrees with cause.");

endmodule

bind ipv6_tcp_service_drop_filter itsdf_checker u_itsdf_checker (.*);

[tb/tb_ipv6_tcp_service_drop_filter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ipv6_tcp_service_drop_filter: directed frames and table
// writes from a stimulus table, then random traffic, checked against table verdicts or a local predictor.
// Depends on itsdf_pkg and the ipv6_tcp_service_drop_filter RTL.
module tb_ipv6_tcp_service_drop_filter;
    import itsdf_pkg::*;

    localparam int SLOTS = 64;

    typedef struct {
        bit         is_write;
        int         len;
        logic [15:0] etype;
        logic [7:0] nh;
        svc_key_t   key;
        logic [5:0] slot;
        logic       slot_on;
        int         mid_pos;
        bit         typed;
        out_beat_t  want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    logic [6:0]  cur_len;
    logic [15:0] cur_etype;
    logic [7:0]  cur_nh;
    logic [63:0] cur_dst_hi;
    logic [63:0] cur_dst_lo;
    logic [15:0] cur_dport;
    logic        svc_on [SLOTS];
    svc_key_t    svc_key [SLOTS];

    out_beat_t verdict_q [$];
    svc_key_t  key_pool [8];
    plan_row_t plan [$];
    int        beats_sent;
    int        errors;
    bit        calm_tail;
    bit        long_hold_req;

    ipv6_tcp_service_drop_filter #(.TABLE_ENTRIES(SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("tb_ipv6_tcp_service_drop_filter: errors");
        $finish;
    end

    function automatic out_beat_t verdict(bit d, cause_t c, bit m, logic [5:0] idx);
        out_beat_t v;
        v.drop = d;
        v.cause = c;
        v.matched = m;
        v.match_index = idx;
        return v;
    endfunction

    function automatic bit filter_step(input in_beat_t b, output out_beat_t v);
        bit         hit;
        logic [5:0] hit_slot;
        v = '0;
        hit = 1'b0;
        hit_slot = '0;
        if (b.req_type == REQ_WRITE) begin
            svc_on[b.entry_index] = b.entry_valid;
            svc_key[b.entry_index] = b.entry_valid ?
                {b.entry_addr_hi, b.entry_addr_lo, b.entry_port} : '0;
            return 1'b0;
        end
        if (cur_len == POS_ETYPE_HI || cur_len == POS_ETYPE_LO) begin
            cur_etype = {cur_etype[7:0], b.pkt_byte};
        end else if (cur_len == POS_NEXT_HDR) begin
            cur_nh = b.pkt_byte;
        end else if (cur_len >= POS_DADDR_HI && cur_len < POS_DADDR_LO) begin
            cur_dst_hi = {cur_dst_hi[55:0], b.pkt_byte};
        end else if (cur_len >= POS_DADDR_LO && cur_len <= POS_DADDR_END) begin
            cur_dst_lo = {cur_dst_lo[55:0], b.pkt_byte};
        end else if (cur_len == POS_DPORT_HI || cur_len == POS_DPORT_LO) begin
            cur_dport = {cur_dport[7:0], b.pkt_byte};
        end
        if (cur_len < LEN_TCP) begin
            cur_len = cur_len + 7'd1;
        end
        if (!b.pkt_last) begin
            return 1'b0;
        end
        if (cur_len < LEN_ETH) begin
            v = verdict(1'b1, CAUSE_TRUNC_ETH, 1'b0, '0);
        end else if (cur_etype != ETYPE_IPV6) begin
            v = verdict(1'b0, CAUSE_NOT_IPV6, 1'b0, '0);
        end else if (cur_len < LEN_IPV6) begin
            v = verdict(1'b1, CAUSE_TRUNC_IPV6, 1'b0, '0);
        end else if (cur_nh != PROTO_TCP) begin
            v = verdict(1'b0, CAUSE_NOT_TCP, 1'b0, '0);
        end else if (cur_len < LEN_TCP) begin
            v = verdict(1'b1, CAUSE_TRUNC_TCP, 1'b0, '0);
        end else begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (svc_on[i] && svc_key[i] == {cur_dst_hi, cur_dst_lo, cur_dport}) begin
                    hit = 1'b1;
                    hit_slot = 6'(i);
                end
            end
            v = verdict(hit, CAUSE_LOOKUP, hit, hit_slot);
        end
        cur_len = '0;
        cur_etype = '0;
        cur_nh = '0;
        cur_dst_hi = '0;
        cur_dst_lo = '0;
        cur_dport = '0;
        return 1'b1;
    endfunction

    function automatic in_beat_t rand_beat();
        bit [191:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r[$bits(in_beat_t)-1:0];
    endfunction

    function automatic svc_key_t rand_key();
        bit [159:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return r[$bits(svc_key_t)-1:0];
    endfunction

    function automatic svc_key_t pick_key();
        if ($urandom_range(0, 9) < 7) begin
            return key_pool[$urandom_range(0, 7)];
        end
        return rand_key();
    endfunction

    function automatic in_beat_t make_write(logic [5:0] slot, logic on, svc_key_t k);
        in_beat_t b;
        b = rand_beat();
        b.req_type = REQ_WRITE;
        b.entry_index = slot;
        b.entry_valid = on;
        b.entry_addr_hi = k.addr_hi;
        b.entry_addr_lo = k.addr_lo;
        b.entry_port = k.port;
        return b;
    endfunction

    function automatic plan_row_t frame_row(int len, logic [15:0] et, logic [7:0] nh,
                                            svc_key_t k);
        plan_row_t r;
        r.is_write = 1'b0;
        r.len = len;
        r.etype = et;
        r.nh = nh;
        r.key = k;
        r.slot = '0;
        r.slot_on = 1'b0;
        r.mid_pos = -1;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t write_row(logic [5:0] slot, logic on, svc_key_t k);
        plan_row_t r;
        r = frame_row(0, '0, '0, k);
        r.is_write = 1'b1;
        r.slot = slot;
        r.slot_on = on;
        return r;
    endfunction

    function automatic plan_row_t checked(plan_row_t r, out_beat_t v);
        r.typed = 1'b1;
        r.want = v;
        return r;
    endfunction

    task automatic push_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        out_beat_t v;
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (filter_step(b, v)) begin
            verdict_q.push_back(typed ? want : v);
        end
    endtask

    task automatic idle(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] nh,
                              input svc_key_t k, input int mid_pos, input logic [5:0] mid_slot,
                              input logic mid_on, input bit churn, input bit typed,
                              input out_beat_t want);
        in_beat_t b;
        bit       gappy;
        gappy = !calm_tail && $urandom_range(0, 2) != 0;
        for (int p = 0; p < len; p++) begin
            if (gappy && $urandom_range(0, 9) == 0) begin
                idle($urandom_range(1, 11));
            end
            if (p == mid_pos) begin
                push_beat(make_write(mid_slot, mid_on, k), 1'b0, want);
            end
            if (churn && $urandom_range(0, 39) == 0) begin
                push_beat(make_write(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                                     pick_key()), 1'b0, want);
            end
            b = rand_beat();
            b.req_type = REQ_PKT;
            b.pkt_last = (p == len - 1);
            if (p == POS_ETYPE_HI) begin
                b.pkt_byte = et[15:8];
            end else if (p == POS_ETYPE_LO) begin
                b.pkt_byte = et[7:0];
            end else if (p == POS_NEXT_HDR) begin
                b.pkt_byte = nh;
            end else if (p >= POS_DADDR_HI && p < POS_DADDR_LO) begin
                b.pkt_byte = k.addr_hi[8 * (POS_DADDR_LO - 1 - p) +: 8];
            end else if (p >= POS_DADDR_LO && p <= POS_DADDR_END) begin
                b.pkt_byte = k.addr_lo[8 * (POS_DADDR_END - p) +: 8];
            end else if (p == POS_DPORT_HI) begin
                b.pkt_byte = k.port[15:8];
            end else if (p == POS_DPORT_LO) begin
                b.pkt_byte = k.port[7:0];
            end
            push_beat(b, typed && p == len - 1, want);
        end
    endtask

    initial begin
        int        stall_left;
        out_beat_t want;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict beat with none expected: %p", m_data);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.drop !== want.drop) begin
                        $error("drop: expected %0d, got %0d", want.drop, m_data.drop);
                        errors++;
                    end
                    if (m_data.cause !== want.cause) begin
                        $error("cause: expected %0d, got %0d", want.cause, m_data.cause);
                        errors++;
                    end
                    if (m_data.matched !== want.matched) begin
                        $error("matched: expected %0d, got %0d", want.matched, m_data.matched);
                        errors++;
                    end
                    if (m_data.match_index !== want.match_index) begin
                        $error("match_index: expected %0d, got %0d",
                               want.match_index, m_data.match_index);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    m_ready <= 1'b1;
                end
            end else if (calm_tail) begin
                m_ready <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = 200;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        svc_key_t  k;
        plan_row_t r;
        int        len;
        int        start_beats;
        bit        paused;
        logic [15:0] et;
        logic [7:0]  nh;

        errors = 0;
        beats_sent = 0;
        calm_tail = 1'b0;
        long_hold_req = 1'b0;
        paused = 1'b0;
        cur_len = '0;
        cur_etype = '0;
        cur_nh = '0;
        cur_dst_hi = '0;
        cur_dst_lo = '0;
        cur_dport = '0;
        for (int i = 0; i < SLOTS; i++) begin
            svc_on[i] = 1'b0;
            svc_key[i] = '0;
        end
        key_pool[0] = '1;
        key_pool[1] = '0;
        for (int i = 2; i < 8; i++) begin
            key_pool[i] = rand_key();
        end

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back(checked(frame_row(1, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_ETH, 1'b0, '0)));
        plan.push_back(checked(frame_row(13, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_ETH, 1'b0, '0)));
        plan.push_back(checked(frame_row(14, 16'h0800, PROTO_TCP, key_pool[0]),
                               verdict(1'b0, CAUSE_NOT_IPV6, 1'b0, '0)));
        plan.push_back(checked(frame_row(14, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_IPV6, 1'b0, '0)));
        plan.push_back(checked(frame_row(53, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_IPV6, 1'b0, '0)));
        plan.push_back(checked(frame_row(54, ETYPE_IPV6, 8'd17, key_pool[0]),
                               verdict(1'b0, CAUSE_NOT_TCP, 1'b0, '0)));
        plan.push_back(checked(frame_row(54, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_TCP, 1'b0, '0)));
        plan.push_back(checked(frame_row(73, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_TRUNC_TCP, 1'b0, '0)));
        plan.push_back(write_row(6'd63, 1'b1, key_pool[0]));
        plan.push_back(checked(frame_row(74, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_LOOKUP, 1'b1, 6'd63)));
        plan.push_back(write_row(6'd0, 1'b1, key_pool[0]));
        plan.push_back(checked(frame_row(76, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_LOOKUP, 1'b1, 6'd0)));
        plan.push_back(write_row(6'd0, 1'b0, key_pool[4]));
        plan.push_back(checked(frame_row(74, ETYPE_IPV6, PROTO_TCP, key_pool[0]),
                               verdict(1'b1, CAUSE_LOOKUP, 1'b1, 6'd63)));
        plan.push_back(checked(frame_row(54, ETYPE_IPV6, 8'hFF, key_pool[0]),
                               verdict(1'b0, CAUSE_NOT_TCP, 1'b0, '0)));
        plan.push_back(checked(frame_row(14, 16'hDD86, PROTO_TCP, key_pool[0]),
                               verdict(1'b0, CAUSE_NOT_IPV6, 1'b0, '0)));
        plan.push_back(write_row(6'd5, 1'b1, key_pool[2]));
        k = key_pool[2];
        k.port[0] = ~k.port[0];
        plan.push_back(frame_row(74, ETYPE_IPV6, PROTO_TCP, k));
        r = frame_row(74, ETYPE_IPV6, PROTO_TCP, key_pool[2]);
        r.mid_pos = 30;
        r.slot = 6'd1;
        r.slot_on = 1'b1;
        plan.push_back(r);
        plan.push_back(write_row(6'd3, 1'b1, key_pool[3]));
        r = frame_row(74, ETYPE_IPV6, PROTO_TCP, key_pool[3]);
        r.mid_pos = 73;
        r.slot = 6'd3;
        r.slot_on = 1'b0;
        plan.push_back(r);
        plan.push_back(write_row(6'd2, 1'b1, key_pool[1]));
        plan.push_back(checked(frame_row(74, ETYPE_IPV6, PROTO_TCP, key_pool[1]),
                               verdict(1'b1, CAUSE_LOOKUP, 1'b1, 6'd2)));

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                push_beat(make_write(plan[i].slot, plan[i].slot_on, plan[i].key), 1'b0, '0);
            end else begin
                send_frame(plan[i].len, plan[i].etype, plan[i].nh, plan[i].key,
                           plan[i].mid_pos, plan[i].slot, plan[i].slot_on, 1'b0,
                           plan[i].typed, plan[i].want);
            end
        end

        drain();
        long_hold_req = 1'b1;
        repeat (40) begin
            send_frame($urandom_range(1, 3), ETYPE_IPV6, PROTO_TCP, pick_key(),
                       -1, '0, 1'b0, 1'b0, 1'b0, '0);
        end

        start_beats = beats_sent;
        while (beats_sent - start_beats < 200) begin
            if (!paused && beats_sent - start_beats >= 100) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) begin
                push_beat(make_write(6'($urandom_range(0, 63)), $urandom_range(0, 4) != 0,
                                     pick_key()), 1'b0, '0);
            end else begin
                k = pick_key();
                if ($urandom_range(0, 4) == 0) begin
                    len = $urandom_range(0, 143);
                    k[len] = ~k[len];
                end
                et = ETYPE_IPV6;
                nh = PROTO_TCP;
                case ($urandom_range(0, 9))
                    0: begin
                        len = $urandom_range(1, 13);
                        et = 16'($urandom);
                    end
                    1: begin
                        len = $urandom_range(14, 90);
                        et = 16'($urandom);
                    end
                    2: len = $urandom_range(14, 53);
                    3: begin
                        len = $urandom_range(54, 90);
                        nh = 8'($urandom);
                    end
                    4: len = $urandom_range(54, 73);
                    default: begin
                        len = ($urandom_range(0, 19) == 0) ? $urandom_range(75, 200)
                                                           : $urandom_range(74, 90);
                    end
                endcase
                send_frame(len, et, nh, k, -1, '0, 1'b0, 1'b1, 1'b0, '0);
            end
        end

        calm_tail = 1'b1;
        repeat (4) begin
            send_frame($urandom_range(1, 20), ETYPE_IPV6, PROTO_TCP,
                       key_pool[$urandom_range(0, 7)], -1, '0, 1'b0, 1'b0, 1'b0, '0);
        end
        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_ipv6_tcp_service_drop_filter: clean");
        end else begin
            $display("tb_ipv6_tcp_service_drop_filter: errors");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/itsdf_pkg.sv
rtl/itsdf_svc_table.sv
rtl/ipv6_tcp_service_drop_filter.sv
rtl/itsdf_checker.sv
tb/tb_ipv6_tcp_service_drop_filter.sv
